### rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// No dependencies; the front end, queue, pixel engine and top level import this package.

package pcxrle_pkg;

    localparam int MAX_LINE_BYTES = 1024;

    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    localparam int COUNT_W    = 6;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int ADDR_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd320;
    localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd200;
    localparam logic [13:0] RST_LINE_STRIDE    = 14'd320;
    localparam logic [10:0] RST_IMAGE_WIDTH    = 11'd320;
    localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd200;
    localparam logic [10:0] RST_BYTES_PER_LINE = 11'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH   = 3'd0,
        REG_SCREEN_HEIGHT  = 3'd1,
        REG_LINE_STRIDE    = 3'd2,
        REG_IMAGE_WIDTH    = 3'd3,
        REG_IMAGE_HEIGHT   = 3'd4,
        REG_BYTES_PER_LINE = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_COUNT_END = 2'd2,
        ERR_EARLY_END = 2'd3
    } t_err;

    typedef enum logic {
        CMD_RUN       = 1'b0,
        CMD_COUNT_ERR = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [COUNT_W-1:0] count;
        logic [7:0]         value;
        logic               last;
    } t_cmd;

endpackage

### rtl/pcxrle_in_if.sv
// Input channel carrying one compressed byte per beat.
// Depends on nothing.

interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/pcxrle_out_if.sv
// Output channel carrying one decoded pixel or error result per beat.
// Depends on nothing.

interface pcxrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [24:0] address;
    logic        visible;
    logic        run_last;
    logic        line_end;
    logic        image_done;
    logic [1:0]  error_code;

    modport source (output valid, output pixel_value, output address, output visible,
                    output run_last, output line_end, output image_done,
                    output error_code, input ready);
    modport sink   (input valid, input pixel_value, input address, input visible,
                    input run_last, input line_end, input image_done,
                    input error_code, output ready);
endinterface

### rtl/pcxrle_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on nothing.

interface pcxrle_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [13:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pcxrle_front.sv
// Front end: accepts compressed bytes and turns them into run commands.
// Depends on pcxrle_pkg and pcxrle_in_if.

module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcxrle_in_if.sink   i_px,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic               r_await;
    logic [COUNT_W-1:0] r_pend;
    logic               accept;
    logic               is_mark;

    assign i_px.ready = !i_full;
    assign accept     = i_px.valid && !i_full;
    assign is_mark    = (i_px.data_byte & RUN_MARK) == RUN_MARK;

    always_comb begin
        o_cmd.kind  = CMD_RUN;
        o_cmd.count = COUNT_W'(1);
        o_cmd.value = i_px.data_byte;
        o_cmd.last  = i_px.last_byte;
        o_push      = accept;
        if (r_await) begin
            o_cmd.count = r_pend;
        end else if (is_mark) begin
            o_cmd.kind = CMD_COUNT_ERR;
            o_push     = accept && i_px.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_pend  <= '0;
        end else if (accept) begin
            if (r_await) begin
                r_await <= 1'b0;
            end else if (is_mark && !i_px.last_byte) begin
                r_await <= 1'b1;
                r_pend  <= COUNT_W'(i_px.data_byte & COUNT_MASK);
            end
        end
    end

endmodule

### rtl/pcxrle_queue.sv
// Short command queue between the front end and the pixel engine.
// Depends on pcxrle_pkg.

module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_cmd  o_cmd,
    output logic  o_empty,
    output logic  o_full
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/pcxrle_back.sv
// Pixel engine: configuration registers, line bookkeeping, run expansion
// and the output register. Depends on pcxrle_pkg and the configuration and output interfaces.

module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    pcxrle_cfg_if.sink    i_cfg,
    pcxrle_out_if.source  o_px
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_STOP} t_state;

    t_state              r_state;
    logic [12:0]         r_sw;
    logic [12:0]         r_sh;
    logic [13:0]         r_stride;
    logic [10:0]         r_iw;
    logic [12:0]         r_ih;
    logic [10:0]         r_bpl;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [ADDR_W-1:0]   r_base;
    logic [COUNT_W-1:0]  r_rem;
    logic [7:0]          r_val;
    logic [2:0]          r_rc;
    logic [11:0]         r_xo;
    logic [13:0]         r_ysum;
    logic [ADDR_W-1:0]   r_prod;

    logic                r_out_valid;
    logic [7:0]          r_out_pix;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_vis;
    logic                r_out_rlast;
    logic                r_out_lend;
    logic                r_out_done;
    t_err                r_out_err;

    logic                cfg_wr;
    logic                slot_free;
    logic                busy;
    logic [COL_W-1:0]    lim;
    logic [COL_W:0]      run_end;
    logic [12:0]         row_next;
    logic                ovf;
    logic                done_here;
    logic                le;
    logic                fin;
    logic [11:0]         x_off;
    logic [11:0]         y_off;
    logic [ADDR_W-1:0]   err_addr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign slot_free   = !r_out_valid || o_px.ready;
    assign busy        = cfg_wr || (r_rc != '0);

    assign lim       = (32'(r_bpl) > MAX_LINE_BYTES) ? COL_W'(MAX_LINE_BYTES) : r_bpl;
    assign run_end   = {1'b0, r_col} + (COL_W+1)'(i_cmd.count);
    assign row_next  = 13'(r_row) + 13'd1;
    assign ovf       = (i_cmd.count != '0) && (run_end > {1'b0, lim});
    assign done_here = (i_cmd.count != '0) && (run_end >= {1'b0, lim}) && (row_next >= r_ih);
    assign le        = ({1'b0, r_col} + (COL_W+1)'(1)) >= {1'b0, lim};
    assign fin       = le && (row_next >= r_ih);
    assign err_addr  = r_base + ADDR_W'(r_col);

    assign x_off = (r_sw >= 13'(r_iw)) ? 12'((r_sw - 13'(r_iw)) >> 1) : '0;
    assign y_off = (r_sh >= r_ih) ? 12'((r_sh - r_ih) >> 1) : '0;

    assign o_pop = !i_empty && ((r_state == S_STOP) ||
                   ((r_state == S_IDLE) && slot_free && !busy));

    assign o_px.valid       = r_out_valid;
    assign o_px.pixel_value = r_out_pix;
    assign o_px.address     = r_out_addr;
    assign o_px.visible     = r_out_vis;
    assign o_px.run_last    = r_out_rlast;
    assign o_px.line_end    = r_out_lend;
    assign o_px.image_done  = r_out_done;
    assign o_px.error_code  = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sw        <= RST_SCREEN_WIDTH;
            r_sh        <= RST_SCREEN_HEIGHT;
            r_stride    <= RST_LINE_STRIDE;
            r_iw        <= RST_IMAGE_WIDTH;
            r_ih        <= RST_IMAGE_HEIGHT;
            r_bpl       <= RST_BYTES_PER_LINE;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_rem       <= '0;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_px.ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_SCREEN_WIDTH:   r_sw     <= i_cfg.data[12:0];
                    REG_SCREEN_HEIGHT:  r_sh     <= i_cfg.data[12:0];
                    REG_LINE_STRIDE:    r_stride <= i_cfg.data;
                    REG_IMAGE_WIDTH:    r_iw     <= i_cfg.data[10:0];
                    REG_IMAGE_HEIGHT:   r_ih     <= i_cfg.data[12:0];
                    REG_BYTES_PER_LINE: r_bpl    <= i_cfg.data[10:0];
                    default:            r_sw     <= r_sw;
                endcase
            end

            r_rc <= {r_rc[1:0], cfg_wr && (i_cfg.index <= REG_BYTES_PER_LINE)};
            if (r_rc[0]) begin
                r_xo   <= x_off;
                r_ysum <= 14'(y_off) + 14'(r_row);
            end
            if (r_rc[1]) begin
                r_prod <= ADDR_W'(r_ysum) * ADDR_W'(r_stride);
            end
            if (r_rc[2]) begin
                r_base <= r_prod + ADDR_W'(r_xo);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_out_pix   <= '0;
                        r_out_addr  <= err_addr;
                        r_out_vis   <= 1'b0;
                        r_out_rlast <= 1'b1;
                        r_out_lend  <= 1'b0;
                        r_out_done  <= 1'b0;
                        if (i_cmd.kind == CMD_COUNT_ERR) begin
                            r_out_err   <= ERR_COUNT_END;
                            r_out_valid <= 1'b1;
                            r_state     <= S_STOP;
                        end else if (ovf) begin
                            r_out_err   <= ERR_OVERFLOW;
                            r_out_valid <= 1'b1;
                            r_state     <= S_STOP;
                        end else if (i_cmd.last && !done_here) begin
                            r_out_err   <= ERR_EARLY_END;
                            r_out_valid <= 1'b1;
                            r_state     <= S_STOP;
                        end else if (i_cmd.count != '0) begin
                            r_rem   <= i_cmd.count;
                            r_val   <= i_cmd.value;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_val;
                        r_out_addr  <= err_addr;
                        r_out_vis   <= r_col < r_iw;
                        r_out_rlast <= r_rem == COUNT_W'(1);
                        r_out_lend  <= le;
                        r_out_done  <= fin;
                        r_out_err   <= ERR_NONE;
                        r_rem       <= r_rem - 1'b1;
                        if (le) begin
                            r_col  <= '0;
                            r_row  <= r_row + 1'b1;
                            r_base <= r_base + ADDR_W'(r_stride);
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (fin) begin
                            r_state <= S_STOP;
                        end else if (r_rem == COUNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_STOP: begin
                    r_state <= S_STOP;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/pcx_rle_scanline_decoder.sv
// Top level of the PCX run-length scanline decoder for 8-bit single-plane images.
// Depends on pcxrle_pkg, the channel interfaces, pcxrle_front, pcxrle_queue, pcxrle_back.
//
// Compressed bytes enter on i_px, one byte per beat, with last_byte set on the final
// byte. Decoded pixels leave on o_px with their framebuffer address and line flags;
// an error ends the stream with a single result that carries a non-zero error code.
// Registers are written on i_cfg, which is always ready; the user must write them only
// while the block is idle, since the block does not enforce it. A register write starts
// a recomputation of the line base address (offsets and row sum, stride product, base),
// during which the pixel engine takes no new command. A literal byte passes through the
// command queue and a command fetch before its pixel is registered at the output, and
// the next command is fetched only after a run's last pixel; a count and value pair
// gives its N pixels at one per cycle after its fetch while the output is not stalled.
// A four-entry command queue separates byte intake from pixel output, so bytes
// keep being taken while the receiver stalls until the queue fills; the output
// register holds its beat for as long as ready stays low.
// After reset the registers hold their defaults, the centred base is zero, and
// the block decodes a new image. After an error or the final pixel of the image
// all further bytes are taken and dropped until the next reset.

module pcx_rle_scanline_decoder
    import pcxrle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcxrle_in_if.sink     i_px,
    pcxrle_cfg_if.sink    i_cfg,
    pcxrle_out_if.source  o_px
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    pcxrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_px),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    pcxrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pcxrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_px    (o_px)
    );

endmodule
